/* rtl/luma_scene_change_detector_core_defines.svh */
// Assertion helpers for the luma scene-change detector.
`ifndef LUMA_SCENE_CHANGE_DETECTOR_CORE_DEFINES_SVH
`define LUMA_SCENE_CHANGE_DETECTOR_CORE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LSCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check a property at every clock edge, reset included.
`define LSCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lscd_pkg.sv */
package lscd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIM_W  = 12;
    localparam int THR_W  = 7;
    localparam int PCT_W  = 7;
    localparam int LUMA_W = 8;
    localparam int CNT_W  = 22;
    localparam int WH_W   = 2 * DIM_W;
    localparam int PROD_W = PCT_W + WH_W;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_PERCENT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd3;

    localparam logic [THR_W-1:0] THR_RESET    = 7'd14;
    localparam logic [PCT_W-1:0] PCT_RESET    = 7'd31;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd720;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [WH_W-1:0]   WH_RESET  = WH_W'(720 * 480);
    localparam logic [PROD_W-1:0] RHS_RESET = PROD_W'(31 * 720 * 480);

    localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [PROD_W-1:0] PCT_SCALE    = PROD_W'(100);
    localparam logic [PROD_W-1:0] COUNT100_MAX = PROD_W'(longint'(COUNT_MAX) * 100);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input int maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end
        return r;
    endfunction

    function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
                                                    input logic [LUMA_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/luma_scene_change_detector_core.sv */
// Channel   Direction  Payload                          Transaction
// s_        in         s_cur_luma, s_prev_luma          one pixel pair, raster order
// m_        out        m_scene_change, m_changed_count  one per frame, after last pixel
// APB       in/out     paddr, pwdata, prdata            one register access
//
// One pixel per cycle while s_ready is high; the line store read and write-back set this rate.
// A frame result passes the s1 stage and then the output register before it shows on m_.
// Reset is synchronous; the line store is not cleared and needs no pass.
// s_ready drops only while a frame result waits on m_ready and the next
// frame's last pixel is ready to report.
module luma_scene_change_detector_core import lscd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LUMA_W-1:0]   s_cur_luma,
    input  logic [LUMA_W-1:0]   s_prev_luma,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_scene_change,
    output logic [CNT_W-1:0]    m_changed_count
);

    logic [THR_W-1:0]  thr_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [WH_W-1:0]   wh_reg;
    logic [WH_W-1:0]   wh_next;
    logic [PROD_W-1:0] rhs_reg;
    logic [PROD_W-1:0] rhs_next;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  w_new;
    logic [DIM_W-1:0]  h_new;
    logic              cfg_wr;
    logic [IDX_W-1:0]  cfg_idx;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              col_end;
    logic              row_end;
    logic              test_above;
    logic              test_below;
    logic              in_acc;

    logic [2*LUMA_W-1:0] row_mem [MAX_WIDTH];
    logic [2*LUMA_W-1:0] mem_q_reg;
    logic              fwd_reg;
    logic [2*LUMA_W-1:0] fwd_data_reg;

    logic              s1_valid_reg;
    logic [LUMA_W-1:0] s1_cur_reg;
    logic [LUMA_W-1:0] s1_prev_reg;
    logic [COL_W-1:0]  s1_x_reg;
    logic              s1_ta_reg;
    logic              s1_tb_reg;
    logic              s1_last_reg;
    logic              s1_adv;
    logic              s1_wr;

    logic [2*LUMA_W-1:0] above;
    logic [LUMA_W-1:0] a_cur;
    logic [LUMA_W-1:0] a_prev;
    logic              pass_a;
    logic              pass_b;
    logic [CNT_W:0]    cnt_sum;
    logic              cnt_sat;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [PROD_W-1:0] c100_reg;
    logic [PROD_W-1:0] c100_next;

    logic              out_valid_reg;
    logic              out_flag_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    assign w_eff = clamp_dim(width_reg, MAX_WIDTH);
    assign h_eff = clamp_dim(height_reg, MAX_HEIGHT);
    assign w_new = (cfg_wr && cfg_idx == REG_WIDTH)
                   ? clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH) : w_eff;
    assign h_new = (cfg_wr && cfg_idx == REG_HEIGHT)
                   ? clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT) : h_eff;
    assign wh_next  = WH_W'(w_new) * WH_W'(h_new);
    assign rhs_next = PROD_W'(pct_reg) * PROD_W'(wh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            pct_reg    <= PCT_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            wh_reg     <= WH_RESET;
            rhs_reg    <= RHS_RESET;
        end else begin
            wh_reg  <= wh_next;
            rhs_reg <= rhs_next;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_THRESHOLD: thr_reg    <= pwdata[THR_W-1:0];
                    REG_PERCENT:   pct_reg    <= pwdata[PCT_W-1:0];
                    REG_WIDTH:     width_reg  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT:    height_reg <= pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (cfg_idx)
                REG_THRESHOLD: prdata = DATA_W'(thr_reg);
                REG_PERCENT:   prdata = DATA_W'(pct_reg);
                REG_WIDTH:     prdata = DATA_W'(width_reg);
                REG_HEIGHT:    prdata = DATA_W'(height_reg);
                default:       prdata = '0;
            endcase
        end
    end

    assign in_acc  = s_valid && s_ready;
    assign col_end = ((DIM_W+1)'(col_reg) + (DIM_W+1)'(1)) >= (DIM_W+1)'(w_eff);
    assign row_end = ((DIM_W+1)'(row_reg) + (DIM_W+1)'(1)) >= (DIM_W+1)'(h_eff);
    assign test_above = row_reg[0]
                        && ((DIM_W+1)'(row_reg) + (DIM_W+1)'(2)) <= (DIM_W+1)'(h_eff);
    assign test_below = row_reg[0] && (row_reg >= ROW_W'(3))
                        && ((DIM_W+1)'(row_reg) + (DIM_W+1)'(1)) <= (DIM_W+1)'(h_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_acc) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    assign s1_adv  = !(s1_last_reg && out_valid_reg && !m_ready);
    assign s1_wr   = s1_valid_reg && s1_adv;
    assign s_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mem_q_reg    <= row_mem[col_reg];
            fwd_reg      <= s1_wr && (s1_x_reg == col_reg);
            fwd_data_reg <= {s1_prev_reg, s1_cur_reg};
        end
        if (s1_wr) begin
            row_mem[s1_x_reg] <= {s1_prev_reg, s1_cur_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_wr) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_cur_reg  <= s_cur_luma;
            s1_prev_reg <= s_prev_luma;
            s1_x_reg    <= col_reg;
            s1_ta_reg   <= test_above;
            s1_tb_reg   <= test_below;
            s1_last_reg <= col_end && row_end;
        end
    end

    assign above  = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign a_cur  = above[LUMA_W-1:0];
    assign a_prev = above[2*LUMA_W-1:LUMA_W];

    assign pass_a = s1_ta_reg
                    && (abs_diff(s1_cur_reg, a_cur) > LUMA_W'(thr_reg))
                    && (abs_diff(s1_cur_reg, s1_prev_reg) > LUMA_W'(thr_reg));
    assign pass_b = s1_tb_reg
                    && (abs_diff(a_cur, s1_prev_reg) > LUMA_W'(thr_reg))
                    && (abs_diff(a_cur, a_prev) > LUMA_W'(thr_reg));

    assign cnt_sum = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(pass_a) + (CNT_W+1)'(pass_b);
    assign cnt_sat = cnt_sum > (CNT_W+1)'(COUNT_MAX);

    always_comb begin
        if (cnt_sat) begin
            cnt_next  = COUNT_MAX;
            c100_next = COUNT100_MAX;
        end else begin
            cnt_next  = cnt_sum[CNT_W-1:0];
            c100_next = c100_reg + (pass_a ? PCT_SCALE : '0) + (pass_b ? PCT_SCALE : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            c100_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_wr) begin
                if (s1_last_reg) begin
                    cnt_reg  <= '0;
                    c100_reg <= '0;
                end else begin
                    cnt_reg  <= cnt_next;
                    c100_reg <= c100_next;
                end
            end
            if (s1_wr && s1_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_wr && s1_last_reg) begin
            out_cnt_reg  <= cnt_next;
            out_flag_reg <= c100_next >= rhs_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_scene_change  = out_flag_reg;
    assign m_changed_count = out_cnt_reg;

endmodule

/* rtl/lscd_checker.sv */
`include "luma_scene_change_detector_core_defines.svh"

module lscd_checker import lscd_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_scene_change,
    input logic [CNT_W-1:0]    m_changed_count
);

    `LSCD_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_changed_count)
            && $stable(m_scene_change),
        "result changed while stalled")
    `LSCD_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready,
        "input stalled without a waiting result")
    `LSCD_ASSERT(a_result_latency, aclk, aresetn,
        $rose(m_valid) |-> $past(s_valid && s_ready, 2),
        "result without a pixel two cycles before")
    `LSCD_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid,
        "result valid after reset")

endmodule

bind luma_scene_change_detector_core lscd_checker u_lscd_checker (.*);

/* dv/luma_scene_change_detector_core_tb.sv */
module luma_scene_change_detector_core_tb;
    import lscd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic             scene_change;
        logic [CNT_W-1:0] changed_count;
    } frame_result_t;

    class scene_scoreboard;
        logic [THR_W-1:0]    threshold;
        logic [PCT_W-1:0]    percent;
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        bit [2*LUMA_W-1:0]   line_mem [MAX_WIDTH];
        int unsigned         col;
        int unsigned         row;
        logic [CNT_W-1:0]    tally;
        frame_result_t       pending_frames [$];
        int unsigned         errors;
        int unsigned         frames_checked;

        function new();
            threshold      = THR_RESET;
            percent        = PCT_RESET;
            width_reg      = WIDTH_RESET;
            height_reg     = HEIGHT_RESET;
            col            = 0;
            row            = 0;
            tally          = '0;
            errors         = 0;
            frames_checked = 0;
        endfunction

        static function int unsigned bounded_dim(logic [DIM_W-1:0] v, int unsigned lim);
            if (v == '0) begin
                return 1;
            end
            if (v > lim) begin
                return lim;
            end
            return v;
        endfunction

        static function int unsigned luma_gap(logic [LUMA_W-1:0] a, logic [LUMA_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_THRESHOLD: threshold  = value[THR_W-1:0];
                REG_PERCENT:   percent    = value[PCT_W-1:0];
                REG_WIDTH:     width_reg  = value[DIM_W-1:0];
                REG_HEIGHT:    height_reg = value[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void bump_tally();
            if (tally != COUNT_MAX) begin
                tally++;
            end
        endfunction

        function void take_pixel(logic [LUMA_W-1:0] cur, logic [LUMA_W-1:0] prv);
            int unsigned       w;
            int unsigned       h;
            int unsigned       th;
            logic [LUMA_W-1:0] up_cur;
            logic [LUMA_W-1:0] up_prev;
            longint unsigned   lhs;
            longint unsigned   rhs;
            frame_result_t     res;
            w       = bounded_dim(width_reg, MAX_WIDTH);
            h       = bounded_dim(height_reg, MAX_HEIGHT);
            th      = threshold;
            up_cur  = line_mem[col][LUMA_W-1:0];
            up_prev = line_mem[col][2*LUMA_W-1:LUMA_W];
            if (row[0] && row + 2 <= h && luma_gap(cur, up_cur) > th
                    && luma_gap(cur, prv) > th) begin
                bump_tally();
            end
            if (row >= 3 && row[0] && row + 1 <= h && luma_gap(up_cur, prv) > th
                    && luma_gap(up_cur, up_prev) > th) begin
                bump_tally();
            end
            line_mem[col] = {prv, cur};
            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) begin
                    lhs = 64'(tally) * 100;
                    rhs = 64'(percent) * w * h;
                    res.scene_change  = (lhs >= rhs);
                    res.changed_count = tally;
                    pending_frames.push_back(res);
                    row   = 0;
                    tally = '0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
            errors++;
        endtask

        task check_frame(logic flag, logic [CNT_W-1:0] count);
            frame_result_t want;
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected frame result flag=%0d count=%0d",
                                          flag, count));
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (flag !== want.scene_change) begin
                    report_mismatch($sformatf("scene_change got %0d want %0d",
                                              flag, want.scene_change));
                end
                if (count !== want.changed_count) begin
                    report_mismatch($sformatf("changed_count got %0d want %0d",
                                              count, want.changed_count));
                end
            end
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [LUMA_W-1:0]   s_cur_luma;
    logic [LUMA_W-1:0]   s_prev_luma;
    logic                m_valid;
    logic                m_ready;
    logic                m_scene_change;
    logic [CNT_W-1:0]    m_changed_count;

    scene_scoreboard sb;
    int burst_left    = 0;
    int src_mode      = 0;
    int sink_mode     = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int settings_used = 0;
    int pixels_sent   = 0;

    luma_scene_change_detector_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cur_luma      (s_cur_luma),
        .s_prev_luma     (s_prev_luma),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scene_change  (m_scene_change),
        .m_changed_count (m_changed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (sink_mode != 0 && $urandom_range(0, 99) < 20 * sink_mode) begin
                stall_left <= $urandom_range(1, 8 * sink_mode);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_frame(m_scene_change, m_changed_count);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task apply_settings(input int thr, input int pct, input int w, input int h);
        s_valid    <= 1'b0;
        burst_left  = 0;
        while (sb.pending_frames.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_PERCENT, pct);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task push_pixel(input logic [LUMA_W-1:0] cur, input logic [LUMA_W-1:0] prv);
        int gap;
        if (burst_left == 0) begin
            gap = (src_mode == 0) ? 0 : $urandom_range(0, 4 * src_mode);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid     <= 1'b1;
        s_cur_luma  <= cur;
        s_prev_luma <= prv;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        pixels_sent++;
        sb.take_pixel(cur, prv);
    endtask

    task push_random_pixel();
        logic [LUMA_W-1:0] cur;
        logic [LUMA_W-1:0] prv;
        int unsigned       th;
        th  = sb.threshold;
        cur = LUMA_W'($urandom_range(0, 255));
        prv = LUMA_W'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            1: prv = cur + LUMA_W'(th + $urandom_range(0, 1));
            2: prv = cur - LUMA_W'(th + $urandom_range(0, 1));
            3: begin
                cur = $urandom_range(0, 1) ? {LUMA_W{1'b1}} : {LUMA_W{1'b0}};
                prv = $urandom_range(0, 1) ? {LUMA_W{1'b1}} : {LUMA_W{1'b0}};
            end
            default: ;
        endcase
        push_pixel(cur, prv);
    endtask

    task run_random_phase(input int thr, input int pct, input int w, input int h,
                          input int frames);
        int n;
        src_mode  = $urandom_range(0, 3);
        sink_mode = $urandom_range(0, 3);
        apply_settings(thr, pct, w, h);
        n = frames * int'(scene_scoreboard::bounded_dim(DIM_W'(w), MAX_WIDTH))
                   * int'(scene_scoreboard::bounded_dim(DIM_W'(h), MAX_HEIGHT));
        repeat (n) push_random_pixel();
    endtask

    initial begin
        int small_items;
        int thr;
        int pct;
        int w;
        int h;
        int frames;
        small_items = 0;
        sb          = new();
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_cur_luma  <= '0;
        s_prev_luma <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // boundary at threshold 125, odd row judged against the row above
        apply_settings(125, 100, 3, 3);
        push_pixel(8'd0, 8'd0);     push_pixel(8'd0, 8'd0);     push_pixel(8'd0, 8'd0);
        push_pixel(8'd255, 8'd0);   push_pixel(8'd126, 8'd0);   push_pixel(8'd125, 8'd0);
        push_pixel(8'd0, 8'd255);   push_pixel(8'd255, 8'd255); push_pixel(8'd128, 8'd128);

        // even row judged against the previous frame below, flag exactly at the share
        sink_mode = 3;
        apply_settings(0, 25, 2, 4);
        push_pixel(8'd10, 8'd10);   push_pixel(8'd20, 8'd20);
        push_pixel(8'd11, 8'd10);   push_pixel(8'd20, 8'd5);
        push_pixel(8'd50, 8'd50);   push_pixel(8'd60, 8'd0);
        push_pixel(8'd255, 8'd0);   push_pixel(8'd0, 8'd255);

        // zero width, short frames, register values at their 7-bit maximum
        sink_mode = 0;
        apply_settings(127, 127, 0, 2);
        push_pixel(8'd0, 8'd255);   push_pixel(8'd255, 8'd0);
        apply_settings(0, 0, 2, 0);
        push_pixel(8'd255, 8'd255); push_pixel(8'd0, 8'd0);

        while (small_items < 1400) begin
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 125;
                2: thr = $urandom_range(126, 127);
                default: thr = $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 5))
                0: pct = 0;
                1: pct = 100;
                2: pct = $urandom_range(101, 127);
                default: pct = $urandom_range(0, 60);
            endcase
            case ($urandom_range(0, 7))
                0: w = 0;
                1: w = 1;
                default: w = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = 1;
                2: h = 2;
                default: h = $urandom_range(3, 8);
            endcase
            frames = $urandom_range(1, 4);
            run_random_phase(thr, pct, w, h, frames);
            small_items += frames
                           * int'(scene_scoreboard::bounded_dim(DIM_W'(w), MAX_WIDTH))
                           * int'(scene_scoreboard::bounded_dim(DIM_W'(h), MAX_HEIGHT));
        end

        s_valid <= 1'b0;
        while (sb.pending_frames.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Run covered %0d pixel transactions and %0d frame results",
                 pixels_sent, sb.frames_checked);
        $display("over %0d register settings, frames from 1x1 up to 12 wide and 8 tall",
                 settings_used);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/lscd_pkg.sv
rtl/luma_scene_change_detector_core.sv
rtl/lscd_checker.sv
dv/luma_scene_change_detector_core_tb.sv
